// ----- rtl/core/epf_pkg.sv -----
// ----------------------------------------------------------------------------
// epf_pkg: shared types and constants for the Eulerian path finder
// Node and edge widths, sequencer step codes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package epf_pkg;

  localparam int unsigned NODE_W    = 6;   // node index width
  localparam int unsigned EDGE_W    = 6;   // edge index width
  localparam int unsigned LINK_W    = 7;   // edge link, top bit marks empty
  localparam int unsigned DIFF_W    = 7;   // signed out minus in degree
  localparam int unsigned CNT_W     = 7;   // counts up to the node count
  localparam int unsigned STEP_W    = 5;

  localparam logic [EDGE_W-1:0] MAX_EDGES = 6'd63;
  localparam logic [LINK_W-1:0] NO_EDGE   = 7'h7f;
  localparam logic [NODE_W-1:0] LAST_NODE = 6'd63;

  // Sequencer steps; the controller state and the datapath command share them.
  localparam logic [STEP_W-1:0] ST_IDLE      = 5'd0;
  localparam logic [STEP_W-1:0] ST_LD_A      = 5'd1;
  localparam logic [STEP_W-1:0] ST_LD_B      = 5'd2;
  localparam logic [STEP_W-1:0] ST_LD_C      = 5'd3;
  localparam logic [STEP_W-1:0] ST_SC_INIT   = 5'd4;
  localparam logic [STEP_W-1:0] ST_SC_RD     = 5'd5;
  localparam logic [STEP_W-1:0] ST_SC_EV     = 5'd6;
  localparam logic [STEP_W-1:0] ST_DECIDE    = 5'd7;
  localparam logic [STEP_W-1:0] ST_DFS_INIT  = 5'd8;
  localparam logic [STEP_W-1:0] ST_DFS_POP   = 5'd9;
  localparam logic [STEP_W-1:0] ST_DFS_TOP   = 5'd10;
  localparam logic [STEP_W-1:0] ST_DFS_E0    = 5'd11;
  localparam logic [STEP_W-1:0] ST_DFS_EDGE  = 5'd12;
  localparam logic [STEP_W-1:0] ST_DFS_VISIT = 5'd13;
  localparam logic [STEP_W-1:0] ST_CHK       = 5'd14;
  localparam logic [STEP_W-1:0] ST_WK_INIT   = 5'd15;
  localparam logic [STEP_W-1:0] ST_WK_TOP    = 5'd16;
  localparam logic [STEP_W-1:0] ST_WK_E      = 5'd17;
  localparam logic [STEP_W-1:0] ST_WK_POP    = 5'd18;
  localparam logic [STEP_W-1:0] ST_WK_PUSH   = 5'd19;
  localparam logic [STEP_W-1:0] ST_EM_RD     = 5'd20;
  localparam logic [STEP_W-1:0] ST_EM_WR     = 5'd21;
  localparam logic [STEP_W-1:0] ST_NOPATH    = 5'd22;
  localparam logic [STEP_W-1:0] ST_CLR       = 5'd23;

  typedef struct packed {
    logic [STEP_W-1:0] op;
    logic              in_take;
  } epf_cmd_t;

  typedef struct packed {
    logic edge_room;
    logic src_eq_dst;
    logic scan_last;
    logic dec_fail;
    logic dfs_sp_zero;
    logic dfs_e_empty;
    logic chk_fail;
    logic wk_empty;
    logic wk_sp_one;
    logic em_last;
    logic out_free;
  } epf_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/epf_dpath.sv -----
// ----------------------------------------------------------------------------
// epf_dpath: Eulerian path finder datapath
// Edge stores, per-node degree and link memories, DFS and walk stacks,
// circuit store and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module epf_dpath import epf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire epf_cmd_t          cmd_i,
  input  wire logic [NODE_W-1:0] edge_source_i,
  input  wire logic [NODE_W-1:0] edge_target_i,
  input  wire logic              out_ready_i,
  output epf_stat_t              stat_o,
  output logic                   out_valid_o,
  output logic [NODE_W-1:0]      path_vertex_o,
  output logic                   path_end_o,
  output logic                   no_path_o
);

  localparam logic signed [DIFF_W-1:0] PLUS1  = 7'sd1;
  localparam logic signed [DIFF_W-1:0] MINUS1 = -7'sd1;

  // memories
  logic signed [DIFF_W-1:0] diff_mem [64];
  logic [LINK_W-1:0]        top_mem  [64];
  logic [NODE_W-1:0]        dest_mem [63];
  logic [LINK_W-1:0]        prev_mem [63];
  logic [NODE_W-1:0]        pend_mem [64];
  logic [NODE_W-1:0]        walk_mem [64];
  logic [NODE_W-1:0]        circ_mem [64];

  logic signed [DIFF_W-1:0] diff_rd_q;
  logic [LINK_W-1:0]        top_rd_q, prev_rd_q;
  logic [NODE_W-1:0]        dest_rd_q, pend_rd_q, walk_rd_q, circ_rd_q;

  // control and working registers
  logic [NODE_W-1:0] src_q, dst_q;
  logic [EDGE_W-1:0] cnt_q;
  logic [CNT_W-1:0]  num_src_q, reach_q;
  logic [63:0]       has_out_q, touched_q, visited_q;
  logic [NODE_W-1:0] i_q, ia_q, ib_q, first_q, start_q, v_q, cur_q, j_q;
  logic [1:0]        nodd_q;
  logic signed [DIFF_W-1:0] da_q, db_q;
  logic              found_q;
  logic [LINK_W-1:0] e_q;
  logic [CNT_W-1:0]  dsp_q, wsp_q, clen_q;
  logic              out_vld_q;
  logic [NODE_W-1:0] out_vtx_q;
  logic              out_end_q, out_nop_q;

  // combinational helpers
  logic signed [DIFF_W-1:0] diff_base, scan_d;
  logic [NODE_W-1:0]        diff_addr;
  logic                     cond_a, cond_b, out_free, out_load;
  logic [NODE_W-1:0]        start_sel;
  logic [LINK_W-1:0]        e_wk;
  logic [CNT_W-1:0]         dsp_m1, wsp_m1, wsp_m2;

  // memory port controls
  logic                     diff_we, diff_re;
  logic [NODE_W-1:0]        diff_wa, diff_ra;
  logic signed [DIFF_W-1:0] diff_wd;
  logic                     top_we, top_re;
  logic [NODE_W-1:0]        top_wa, top_ra;
  logic [LINK_W-1:0]        top_wd;
  logic                     edg_we, edg_re;
  logic [EDGE_W-1:0]        edg_ra;
  logic                     pend_we, pend_re;
  logic [NODE_W-1:0]        pend_wa, pend_wd;
  logic                     walk_we, walk_re;
  logic                     circ_we, circ_re;

  assign diff_addr = (cmd_i.op == ST_LD_B) ? src_q : dst_q;
  assign diff_base = touched_q[diff_addr] ? diff_rd_q : '0;
  assign scan_d    = touched_q[i_q] ? diff_rd_q : '0;
  assign cond_a    = (da_q == PLUS1) && (db_q == MINUS1);
  assign cond_b    = (da_q == MINUS1) && (db_q == PLUS1);
  assign start_sel = (nodd_q == 2'd2) ? (cond_a ? ia_q : ib_q)
                                      : (found_q ? first_q : '0);
  assign e_wk      = has_out_q[cur_q] ? top_rd_q : NO_EDGE;
  assign out_free  = !out_vld_q || out_ready_i;
  assign out_load  = ((cmd_i.op == ST_EM_WR) || (cmd_i.op == ST_NOPATH)) && out_free;
  assign dsp_m1    = dsp_q - 7'd1;
  assign wsp_m1    = wsp_q - 7'd1;
  assign wsp_m2    = wsp_q - 7'd2;

  always_comb begin
    stat_o.edge_room   = (cnt_q != MAX_EDGES);
    stat_o.src_eq_dst  = (src_q == dst_q);
    stat_o.scan_last   = (i_q == LAST_NODE);
    stat_o.dec_fail    = (nodd_q == 2'd3) || (nodd_q == 2'd1) ||
                         ((nodd_q == 2'd2) && !cond_a && !cond_b);
    stat_o.dfs_sp_zero = (dsp_q == '0);
    stat_o.dfs_e_empty = e_q[LINK_W-1];
    stat_o.chk_fail    = (reach_q != num_src_q);
    stat_o.wk_empty    = e_wk[LINK_W-1];
    stat_o.wk_sp_one   = (wsp_q == 7'd1);
    stat_o.em_last     = (j_q == '0);
    stat_o.out_free    = out_free;
  end

  always_comb begin
    diff_we = 1'b0; diff_wa = src_q; diff_wd = diff_base + PLUS1;
    diff_re = 1'b0; diff_ra = src_q;
    top_we  = 1'b0; top_wa  = src_q; top_wd  = {1'b0, cnt_q};
    top_re  = 1'b0; top_ra  = src_q;
    edg_we  = 1'b0; edg_re  = 1'b0; edg_ra = e_q[EDGE_W-1:0];
    pend_we = 1'b0; pend_wa = '0;   pend_wd = start_q; pend_re = 1'b0;
    walk_we = 1'b0; walk_re = 1'b0;
    circ_we = 1'b0; circ_re = 1'b0;
    unique case (cmd_i.op)
      ST_LD_A: begin
        diff_re = 1'b1;
        top_re  = 1'b1;
      end
      ST_LD_B: begin
        diff_we = !stat_o.src_eq_dst;
        diff_re = 1'b1;
        diff_ra = dst_q;
        top_we  = 1'b1;
        edg_we  = 1'b1;
      end
      ST_LD_C: begin
        diff_we = 1'b1;
        diff_wa = dst_q;
        diff_wd = diff_base + MINUS1;
      end
      ST_SC_RD: begin
        diff_re = 1'b1;
        diff_ra = i_q;
      end
      ST_DFS_INIT: pend_we = 1'b1;
      ST_DFS_POP:  pend_re = !stat_o.dfs_sp_zero;
      ST_DFS_TOP: begin
        top_re = 1'b1;
        top_ra = pend_rd_q;
      end
      ST_DFS_EDGE: edg_re = !e_q[LINK_W-1];
      ST_DFS_VISIT: begin
        pend_we = !visited_q[dest_rd_q];
        pend_wa = dsp_q[NODE_W-1:0];
        pend_wd = dest_rd_q;
      end
      ST_WK_TOP: begin
        top_re = 1'b1;
        top_ra = cur_q;
      end
      ST_WK_E: begin
        circ_we = e_wk[LINK_W-1];
        walk_re = e_wk[LINK_W-1] && !stat_o.wk_sp_one;
        edg_re  = !e_wk[LINK_W-1];
        edg_ra  = e_wk[EDGE_W-1:0];
      end
      ST_WK_PUSH: begin
        top_we  = 1'b1;
        top_wa  = cur_q;
        top_wd  = prev_rd_q;
        walk_we = 1'b1;
      end
      ST_EM_RD: circ_re = 1'b1;
      default: ;
    endcase
  end

  // memory arrays
  always_ff @(posedge clk_i) begin
    if (diff_we) diff_mem[diff_wa] <= diff_wd;
    if (diff_re) diff_rd_q <= diff_mem[diff_ra];
  end

  always_ff @(posedge clk_i) begin
    if (top_we) top_mem[top_wa] <= top_wd;
    if (top_re) top_rd_q <= top_mem[top_ra];
  end

  always_ff @(posedge clk_i) begin
    if (edg_we) begin
      dest_mem[cnt_q] <= dst_q;
      prev_mem[cnt_q] <= has_out_q[src_q] ? top_rd_q : NO_EDGE;
    end
    if (edg_re) begin
      dest_rd_q <= dest_mem[edg_ra];
      prev_rd_q <= prev_mem[edg_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) pend_mem[pend_wa] <= pend_wd;
    if (pend_re) pend_rd_q <= pend_mem[dsp_m1[NODE_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (walk_we) walk_mem[wsp_m1[NODE_W-1:0]] <= cur_q;
    if (walk_re) walk_rd_q <= walk_mem[wsp_m2[NODE_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (circ_we) circ_mem[clen_q[NODE_W-1:0]] <= cur_q;
    if (circ_re) circ_rd_q <= circ_mem[j_q];
  end

  // working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= '0; dst_q <= '0; cnt_q <= '0;
      num_src_q <= '0; reach_q <= '0;
      has_out_q <= '0; touched_q <= '0; visited_q <= '0;
      i_q <= '0; ia_q <= '0; ib_q <= '0; first_q <= '0; start_q <= '0;
      v_q <= '0; cur_q <= '0; j_q <= '0;
      nodd_q <= '0; da_q <= '0; db_q <= '0; found_q <= 1'b0;
      e_q <= NO_EDGE; dsp_q <= '0; wsp_q <= '0; clen_q <= '0;
      out_vld_q <= 1'b0; out_vtx_q <= '0; out_end_q <= 1'b0; out_nop_q <= 1'b0;
    end else begin
      if (out_load)         out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
      if (cmd_i.in_take) begin
        src_q <= edge_source_i;
        dst_q <= edge_target_i;
      end
      unique case (cmd_i.op)
        ST_LD_B: begin
          has_out_q[src_q] <= 1'b1;
          if (!has_out_q[src_q]) num_src_q <= num_src_q + 7'd1;
          if (!stat_o.src_eq_dst) touched_q[src_q] <= 1'b1;
          cnt_q <= cnt_q + 6'd1;
        end
        ST_LD_C: touched_q[dst_q] <= 1'b1;
        ST_SC_INIT: begin
          i_q <= '0; nodd_q <= '0; found_q <= 1'b0; first_q <= '0;
        end
        ST_SC_EV: begin
          if (scan_d != '0) begin
            unique case (nodd_q)
              2'd0: begin ia_q <= i_q; da_q <= scan_d; nodd_q <= 2'd1; end
              2'd1: begin ib_q <= i_q; db_q <= scan_d; nodd_q <= 2'd2; end
              default: nodd_q <= 2'd3;
            endcase
          end
          if (has_out_q[i_q] && !found_q) begin
            first_q <= i_q;
            found_q <= 1'b1;
          end
          i_q <= i_q + 6'd1;
        end
        ST_DECIDE: start_q <= start_sel;
        ST_DFS_INIT: begin
          visited_q[start_q] <= 1'b1;
          dsp_q   <= 7'd1;
          reach_q <= {6'd0, has_out_q[start_q]};
        end
        ST_DFS_POP: if (!stat_o.dfs_sp_zero) dsp_q <= dsp_m1;
        ST_DFS_TOP: v_q <= pend_rd_q;
        ST_DFS_E0:  e_q <= has_out_q[v_q] ? top_rd_q : NO_EDGE;
        ST_DFS_VISIT: begin
          if (!visited_q[dest_rd_q]) begin
            visited_q[dest_rd_q] <= 1'b1;
            dsp_q   <= dsp_q + 7'd1;
            reach_q <= reach_q + {6'd0, has_out_q[dest_rd_q]};
          end
          e_q <= prev_rd_q;
        end
        ST_WK_INIT: begin
          cur_q <= start_q; wsp_q <= 7'd1; clen_q <= '0;
        end
        ST_WK_E: if (e_wk[LINK_W-1]) begin
          clen_q <= clen_q + 7'd1;
          wsp_q  <= wsp_m1;
          j_q    <= clen_q[NODE_W-1:0];
        end
        ST_WK_POP: cur_q <= walk_rd_q;
        ST_WK_PUSH: begin
          cur_q <= dest_rd_q;
          wsp_q <= wsp_q + 7'd1;
        end
        ST_EM_WR: if (out_free) begin
          out_vtx_q <= circ_rd_q;
          out_end_q <= (j_q == '0);
          out_nop_q <= 1'b0;
          if (j_q != '0) j_q <= j_q - 6'd1;
        end
        ST_NOPATH: if (out_free) begin
          out_vtx_q <= '0;
          out_end_q <= 1'b1;
          out_nop_q <= 1'b1;
        end
        ST_CLR: begin
          has_out_q <= '0; touched_q <= '0; visited_q <= '0;
          cnt_q <= '0; num_src_q <= '0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o   = out_vld_q;
  assign path_vertex_o = out_vtx_q;
  assign path_end_o    = out_end_q;
  assign no_path_o     = out_nop_q;

endmodule

`default_nettype wire

// ----- rtl/core/epf_ctrl.sv -----
// ----------------------------------------------------------------------------
// epf_ctrl: Eulerian path finder sequencer
// Steps through edge loading, degree scan, reachability search, stack walk,
// result emission and store clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module epf_ctrl import epf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      edge_present_i,
  input  wire logic      final_edge_i,
  input  wire epf_stat_t stat_i,
  output logic           in_ready_o,
  output epf_cmd_t       cmd_o
);

  logic [STEP_W-1:0] state_q, state_d;
  logic              final_q;
  logic              take;

  assign in_ready_o    = (state_q == ST_IDLE);
  assign take          = in_valid_i && in_ready_o;
  assign cmd_o.op      = state_q;
  assign cmd_o.in_take = take;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (edge_present_i && stat_i.edge_room) state_d = ST_LD_A;
          else if (final_edge_i)                  state_d = ST_SC_INIT;
        end
      end
      ST_LD_A: state_d = ST_LD_B;
      ST_LD_B: begin
        if (!stat_i.src_eq_dst) state_d = ST_LD_C;
        else                    state_d = final_q ? ST_SC_INIT : ST_IDLE;
      end
      ST_LD_C:      state_d = final_q ? ST_SC_INIT : ST_IDLE;
      ST_SC_INIT:   state_d = ST_SC_RD;
      ST_SC_RD:     state_d = ST_SC_EV;
      ST_SC_EV:     state_d = stat_i.scan_last ? ST_DECIDE : ST_SC_RD;
      ST_DECIDE:    state_d = stat_i.dec_fail ? ST_NOPATH : ST_DFS_INIT;
      ST_DFS_INIT:  state_d = ST_DFS_POP;
      ST_DFS_POP:   state_d = stat_i.dfs_sp_zero ? ST_CHK : ST_DFS_TOP;
      ST_DFS_TOP:   state_d = ST_DFS_E0;
      ST_DFS_E0:    state_d = ST_DFS_EDGE;
      ST_DFS_EDGE:  state_d = stat_i.dfs_e_empty ? ST_DFS_POP : ST_DFS_VISIT;
      ST_DFS_VISIT: state_d = ST_DFS_EDGE;
      ST_CHK:       state_d = stat_i.chk_fail ? ST_NOPATH : ST_WK_INIT;
      ST_WK_INIT:   state_d = ST_WK_TOP;
      ST_WK_TOP:    state_d = ST_WK_E;
      ST_WK_E: begin
        if (!stat_i.wk_empty)      state_d = ST_WK_PUSH;
        else if (stat_i.wk_sp_one) state_d = ST_EM_RD;
        else                       state_d = ST_WK_POP;
      end
      ST_WK_POP:  state_d = ST_WK_TOP;
      ST_WK_PUSH: state_d = ST_WK_TOP;
      ST_EM_RD:   state_d = ST_EM_WR;
      ST_EM_WR: begin
        if (stat_i.out_free) state_d = stat_i.em_last ? ST_CLR : ST_EM_RD;
      end
      ST_NOPATH: if (stat_i.out_free) state_d = ST_CLR;
      ST_CLR:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take) final_q <= final_edge_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/eulerian_path_finder_unit.sv -----
// ----------------------------------------------------------------------------
// eulerian_path_finder_unit: directed-graph Eulerian path search
// Loads edges one per transfer, then searches and emits the path or no_path.
// ----------------------------------------------------------------------------
// Each input transfer may carry one directed edge (up to 63 per graph; later
// ones are dropped). An edge transfer occupies the block for a read step and
// one degree-memory write each for source and target (none for a self-loop),
// bounded by the single write port of the degree memory. The transfer
// flagged final_edge starts the search: a degree scan (one setup step, then
// one memory read and one evaluate per node), a reachability search, a stack
// walk, then the results, each read from the circuit store and held in the
// output register while the output side stalls. Results are the path
// vertices in forward order with path_end on the last, or a single no_path
// result. A final clear step restores all stores; no new transfer is taken
// until then, but the last result may still wait in the output register
// while the next graph loads.
// ----------------------------------------------------------------------------
`default_nettype none

module eulerian_path_finder_unit import epf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [NODE_W-1:0] edge_source_i,
  input  wire logic [NODE_W-1:0] edge_target_i,
  input  wire logic              edge_present_i,
  input  wire logic              final_edge_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [NODE_W-1:0]      path_vertex_o,
  output logic                   path_end_o,
  output logic                   no_path_o
);

  epf_cmd_t  cmd;
  epf_stat_t stat;

  // sequencer: owns the step and the input handshake
  epf_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .edge_present_i (edge_present_i),
    .final_edge_i   (final_edge_i),
    .stat_i         (stat),
    .in_ready_o     (in_ready_o),
    .cmd_o          (cmd)
  );

  // datapath: memories, stacks and the result register
  epf_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .edge_source_i (edge_source_i),
    .edge_target_i (edge_target_i),
    .out_ready_i   (out_ready_i),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .path_vertex_o (path_vertex_o),
    .path_end_o    (path_end_o),
    .no_path_o     (no_path_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/epf_checker.sv -----
// ----------------------------------------------------------------------------
// epf_checker: port-level checks for the Eulerian path finder
// Watches the top-level ports and flags result and handshake slips.
// ----------------------------------------------------------------------------
`default_nettype none

module epf_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       final_edge_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [5:0] path_vertex_o,
  input wire logic       path_end_o,
  input wire logic       no_path_o
);

  // a failed search gives one closing result with vertex zero
  a_nopath_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_path_o |-> path_end_o && (path_vertex_o == 6'd0))
    else $error("no_path result not closing or vertex nonzero");

  // the final transfer starts the search, so input must close
  a_final_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && final_edge_i |=> !in_ready_o)
    else $error("input still open after final transfer");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(path_vertex_o)
      && $stable(path_end_o) && $stable(no_path_o))
    else $error("stalled result changed");

  // reset empties the result register
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind eulerian_path_finder_unit epf_checker u_epf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .final_edge_i  (final_edge_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .path_vertex_o (path_vertex_o),
  .path_end_o    (path_end_o),
  .no_path_o     (no_path_o)
);

`default_nettype wire
